@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define ASSERT_SAME(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error(msg);

`endif

@@ design/ssd_pkg.sv @@
`timescale 1ns / 1ps

package ssd_pkg;

  localparam int unsigned TPOS_W = 17;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned LEN_W  = 5;

  localparam logic [1:0] REG_PAT_LOW  = 2'd0;
  localparam logic [1:0] REG_PAT_HIGH = 2'd1;
  localparam logic [1:0] REG_PAT_LEN  = 2'd2;
  localparam logic [1:0] REG_DBCS     = 2'd3;

  typedef enum logic [1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_TOO_LONG  = 2'd2
  } status_e;

  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] position;
  } result_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  function automatic logic is_lead(input logic [7:0] b);
    logic lead;
    lead = 1'b0;
    case (b) inside
      [8'h81:8'h9F], [8'hE0:8'hFC]: lead = 1'b1;
      default: lead = 1'b0;
    endcase
    return lead;
  endfunction

endpackage

@@ design/ssd_cell.sv @@
`timescale 1ns / 1ps

module ssd_cell import ssd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic [7:0] byte_i,
  input  logic       allowed_i,
  input  logic [7:0] pat_i,
  input  logic       mask_i,
  input  logic       sel_i,
  output logic [7:0] byte_o,
  output logic       allowed_o,
  output logic       ok_o,
  output logic       start_o
);

  logic [7:0] byte_q;
  logic       allowed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q    <= '0;
      allowed_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      byte_q    <= '0;
      allowed_q <= 1'b0;
    end else if (ctrl_i.shift) begin
      byte_q    <= byte_i;
      allowed_q <= allowed_i;
    end
  end

  // compare against the byte that lands here on this shift
  assign ok_o      = mask_i | (byte_i == pat_i);
  assign start_o   = sel_i & allowed_i;
  assign byte_o    = byte_q;
  assign allowed_o = allowed_q;

endmodule

@@ design/ssd_skid.sv @@
`timescale 1ns / 1ps

module ssd_skid import ssd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_data_o
);

  logic    head_vld_q, head_vld_d;
  logic    skid_vld_q, skid_vld_d;
  result_t head_q, head_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop = head_vld_q & ~out_stall_i;

  always_comb begin
    head_vld_d = head_vld_q;
    skid_vld_d = skid_vld_q;
    head_d     = head_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (pop) begin
        head_d     = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (head_vld_q) begin
      if (push_i && pop) begin
        head_d = push_data_i;
      end else if (push_i) begin
        skid_d     = push_data_i;
        skid_vld_d = 1'b1;
      end else if (pop) begin
        head_vld_d = 1'b0;
      end
    end else if (push_i) begin
      head_d     = push_data_i;
      head_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      head_vld_q <= head_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_vld_q;
  assign out_valid_o = head_vld_q;
  assign out_data_o  = head_q;

endmodule

@@ design/substring_search_dbcs_aware.sv @@
// Streaming first-match substring search with optional Shift-JIS boundary rule.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_index_i
// (pattern low bytes, pattern high bytes, pattern length, double-byte mode);
// write only between requests, when no result is outstanding.
// Input channel: one text byte per request, last_byte_i marks the end of a text.
// A request is taken when in_valid_i is high and in_stall_o is low.
// Output channel: at most one result per text (found with position, not found
// at the last byte, or too long), moved when out_valid_o is high and
// out_stall_i is low.
// A result is registered in the output slots. Throughput: one byte per cycle
// while in_stall_o is low, set by the row of window cells that shift and
// compare the newest PATTERN_MAX bytes in parallel on every request.
// The output side has a result register plus one skid slot; in_stall_o rises
// only while both hold results that the receiver has not taken.
// Reset clears the window, position, mode state and config registers to zero;
// after each last byte the search state clears again, registers are kept.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module substring_search_dbcs_aware import ssd_pkg::*; #(
  parameter int unsigned PATTERN_MAX = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  search_status_o,
  output logic [15:0] match_position_o
);

  logic [63:0]      pat_low_q, pat_high_q;
  logic [LEN_W-1:0] pat_len_q;
  logic             dbcs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= '0;
      dbcs_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_PAT_LOW:  pat_low_q  <= cfg_wdata_i;
        REG_PAT_HIGH: pat_high_q <= cfg_wdata_i;
        REG_PAT_LEN:  pat_len_q  <= cfg_wdata_i[LEN_W-1:0];
        REG_DBCS:     dbcs_q     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  logic [15:0][7:0] pat_bytes;
  logic [LEN_W-1:0] len_eff;

  assign pat_bytes = {pat_high_q, pat_low_q};
  assign len_eff   = (pat_len_q > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : pat_len_q;

  logic              skip_q, skip_d;
  logic [TPOS_W-1:0] tpos_q, tpos_d;
  logic              done_q, done_d;
  logic              accept, active, allowed;
  cell_ctrl_t        cell_ctrl;

  assign accept = in_valid_i & ~in_stall_o;
  assign active = accept & ~done_q;

  always_comb begin
    allowed = 1'b1;
    skip_d  = skip_q;
    if (dbcs_q) begin
      if (skip_q) begin
        allowed = 1'b0;
        skip_d  = 1'b0;
      end else begin
        skip_d = is_lead(text_byte_i);
      end
    end
  end

  assign cell_ctrl.shift = active;
  assign cell_ctrl.clear = accept & last_byte_i;

  logic [PATTERN_MAX-1:0][7:0] win_byte;
  logic [PATTERN_MAX-1:0]      win_allowed;
  logic [PATTERN_MAX-1:0]      ok_vec;
  logic [PATTERN_MAX-1:0]      start_vec;

  for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
    localparam logic [LEN_W-1:0] K = LEN_W'(g);
    logic [LEN_W-1:0] pidx;
    logic [7:0]       cell_byte_in;
    logic             cell_allowed_in;

    // cell k lines up with pattern byte len-1-k
    assign pidx = len_eff - K - LEN_W'(1);

    if (g == 0) begin : g_head
      assign cell_byte_in    = text_byte_i;
      assign cell_allowed_in = allowed;
    end else begin : g_body
      assign cell_byte_in    = win_byte[g-1];
      assign cell_allowed_in = win_allowed[g-1];
    end

    ssd_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (cell_ctrl),
      .byte_i    (cell_byte_in),
      .allowed_i (cell_allowed_in),
      .pat_i     (pat_bytes[pidx[3:0]]),
      .mask_i    (K >= len_eff),
      .sel_i     (len_eff == K + LEN_W'(1)),
      .byte_o    (win_byte[g]),
      .allowed_o (win_allowed[g]),
      .ok_o      (ok_vec[g]),
      .start_o   (start_vec[g])
    );
  end

  logic [TPOS_W-1:0] len_m1, start_pos;
  logic              empty_pat, hit, too_long, push;
  result_t           res;

  assign len_m1    = TPOS_W'(len_eff) - TPOS_W'(1);
  assign start_pos = tpos_q - len_m1;
  assign empty_pat = (len_eff == '0);

  assign hit = empty_pat |
               ((&ok_vec) & (|start_vec) & (tpos_q >= len_m1) & ~start_pos[TPOS_W-1]);
  // position saturates at 65536, flagged by its top bit
  assign too_long = ~hit & tpos_q[TPOS_W-1];
  assign push     = active & (hit | too_long | last_byte_i);

  always_comb begin
    res.status   = STATUS_NOT_FOUND;
    res.position = '0;
    if (hit) begin
      res.status   = STATUS_FOUND;
      res.position = empty_pat ? '0 : start_pos[POS_W-1:0];
    end else if (too_long) begin
      res.status = STATUS_TOO_LONG;
    end
  end

  always_comb begin
    tpos_d = tpos_q;
    done_d = done_q;
    if (active) begin
      if (hit || too_long) begin
        done_d = 1'b1;
      end else begin
        tpos_d = tpos_q + TPOS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_q <= 1'b0;
      tpos_q <= '0;
      done_q <= 1'b0;
    end else if (accept && last_byte_i) begin
      skip_q <= 1'b0;
      tpos_q <= '0;
      done_q <= 1'b0;
    end else if (active) begin
      skip_q <= skip_d;
      tpos_q <= tpos_d;
      done_q <= done_d;
    end
  end

  result_t out_res;

  ssd_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (res),
    .full_o      (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_res)
  );

  assign search_status_o  = out_res.status;
  assign match_position_o = out_res.position;

  // a full skid slot means the head slot holds a result as well
  `ASSERT_SAME(a_full_has_head, clk_i, rst_ni, in_stall_o, out_valid_o,
               "skid slot full while head slot empty")
  // once a text reported, the rest of it yields nothing
  `ASSERT_SAME(a_done_silent, clk_i, rst_ni, done_q && accept, !push,
               "result produced after search finished")
  // end of text clears the search state
  `ASSERT_NEXT(a_last_clears, clk_i, rst_ni, accept && last_byte_i,
               tpos_q == '0 && !done_q && !skip_q, "state not cleared after last byte")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench import ssd_pkg::*; ();

  localparam int QUIET_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 900;

  typedef enum logic [1:0] {
    CHK_MODEL,
    CHK_RESULT,
    CHK_NONE
  } check_e;

  typedef struct packed {
    logic        is_cfg;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [4:0]  len;
    logic        mode;
    logic [7:0]  b;
    logic        is_last;
    check_e      chk;
    status_e     st;
    logic [15:0] pos;
  } plan_row_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        cfg_we_i    = 1'b0;
  logic [1:0]  cfg_index_i = REG_PAT_LOW;
  logic [63:0] cfg_wdata_i = '0;
  logic        in_valid_i  = 1'b0;
  logic [7:0]  text_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        out_stall_i = 1'b0;
  logic        in_stall_o;
  logic        out_valid_o;
  logic [1:0]  search_status_o;
  logic [15:0] match_position_o;

  int idle_pct     = 0;
  int stall_pct    = 0;
  int quiet_cycles = 0;
  int mismatches   = 0;

  result_t pending_results[$];

  // search state and register copies kept by the predictor
  logic [127:0] cfg_pattern = '0;
  logic [4:0]   cfg_len     = '0;
  logic         cfg_dbcs    = 1'b0;
  logic [7:0]   win_bytes[16];
  logic         win_start[16];
  logic         in_trail    = 1'b0;
  logic [16:0]  text_pos    = '0;
  logic         search_over = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  substring_search_dbcs_aware uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .text_byte_i     (text_byte_i),
    .last_byte_i     (last_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .search_status_o (search_status_o),
    .match_position_o(match_position_o)
  );

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result with none pending: status %0d position %0d",
                                search_status_o, match_position_o));
      end else begin
        want = pending_results.pop_front();
        if (search_status_o !== want.status || match_position_o !== want.position) begin
          flag_mismatch($sformatf("status exp %0d got %0d, position exp %0d got %0d",
                                  want.status, search_status_o, want.position,
                                  match_position_o));
        end
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // one text byte through the search; returns 1 when it produces a result
  function automatic bit search_step(input logic [7:0] b, input logic is_last,
                                     output result_t r);
    logic        may_start;
    logic        hit;
    logic        got;
    logic        same;
    logic [16:0] start;
    int          len;
    hit = 1'b0;
    got = 1'b0;
    r.status = STATUS_FOUND;
    r.position = '0;
    if (!search_over) begin
      if (!cfg_dbcs) begin
        may_start = 1'b1;
      end else if (in_trail) begin
        may_start = 1'b0;
        in_trail = 1'b0;
      end else begin
        may_start = 1'b1;
        in_trail = (b >= 8'h81 && b <= 8'h9F) || (b >= 8'hE0 && b <= 8'hFC);
      end
      for (int i = 15; i > 0; i--) begin
        win_bytes[i] = win_bytes[i-1];
        win_start[i] = win_start[i-1];
      end
      win_bytes[0] = b;
      win_start[0] = may_start;
      len = (cfg_len > 5'd16) ? 16 : int'(cfg_len);
      if (len == 0) begin
        hit = 1'b1;
      end else if (text_pos >= 17'(len - 1) && win_start[len-1]) begin
        start = text_pos - 17'(len - 1);
        same = 1'b1;
        for (int i = 0; i < len; i++) begin
          if (cfg_pattern[i*8 +: 8] != win_bytes[len-1-i]) same = 1'b0;
        end
        if (same && start < 17'h10000) begin
          hit = 1'b1;
          r.position = start[15:0];
        end
      end
      if (hit) begin
        got = 1'b1;
        search_over = 1'b1;
      end else if (text_pos >= 17'h10000) begin
        r.status = STATUS_TOO_LONG;
        r.position = '0;
        got = 1'b1;
        search_over = 1'b1;
      end else begin
        text_pos = text_pos + 17'd1;
      end
      if (is_last && !got) begin
        r.status = STATUS_NOT_FOUND;
        r.position = '0;
        got = 1'b1;
      end
    end
    if (is_last) begin
      for (int i = 0; i < 16; i++) begin
        win_bytes[i] = '0;
        win_start[i] = 1'b0;
      end
      in_trail = 1'b0;
      text_pos = '0;
      search_over = 1'b0;
    end
    return got;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    last_byte_i <= is_last;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic send_and_predict(input logic [7:0] b, input logic is_last);
    result_t r;
    send_byte(b, is_last);
    if (search_step(b, is_last, r)) pending_results.push_back(r);
  endtask

  // hold off requests until every pending result is out
  task automatic settle(input int extra);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic load_search(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [4:0] len, input logic mode);
    logic [63:0] fill;
    settle(4);
    fill = {$urandom, $urandom};
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_PAT_LOW;
    cfg_wdata_i <= lo;
    @(posedge clk_i);
    cfg_index_i <= REG_PAT_HIGH;
    cfg_wdata_i <= hi;
    @(posedge clk_i);
    cfg_index_i <= REG_PAT_LEN;
    cfg_wdata_i <= {fill[63:5], len};
    @(posedge clk_i);
    cfg_index_i <= REG_DBCS;
    cfg_wdata_i <= {fill[62:0], mode};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_pattern = {hi, lo};
    cfg_len     = len;
    cfg_dbcs    = mode;
  endtask

  // two ASCII letters, bytes on and just outside the lead ranges, plus some fully random ones
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    case ($urandom_range(9))
      0: b = 8'h41;
      1: b = 8'h42;
      2: b = 8'h81;
      3: b = 8'h9F;
      4: b = 8'hE0;
      5: b = 8'hFC;
      6: b = 8'h80;
      7: begin
        case ($urandom_range(2))
          0: b = 8'hA0;
          1: b = 8'hDF;
          default: b = 8'hFD;
        endcase
      end
      default: b = 8'($urandom_range(255));
    endcase
    return b;
  endfunction

  function automatic plan_row_t cfg_row(input logic [63:0] lo, input logic [63:0] hi,
                                        input logic [4:0] len, input logic mode);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.lo = lo;
    row.hi = hi;
    row.len = len;
    row.mode = mode;
    return row;
  endfunction

  function automatic plan_row_t text_row(input logic [7:0] b, input logic is_last,
                                         input check_e chk, input status_e st,
                                         input logic [15:0] pos);
    plan_row_t row;
    row = '0;
    row.b = b;
    row.is_last = is_last;
    row.chk = chk;
    row.st = st;
    row.pos = pos;
    return row;
  endfunction

  initial begin
    plan_row_t    plan[$];
    result_t      r;
    logic [7:0]   txt[$];
    logic [127:0] pat;
    int           eff;
    int           n;
    int           kind;
    int           ofs;
    int           idx;
    int           phase_items;

    for (int i = 0; i < 16; i++) begin
      win_bytes[i] = '0;
      win_start[i] = 1'b0;
    end

    // empty pattern right after reset
    plan.push_back(text_row(8'h00, 1'b0, CHK_RESULT, STATUS_FOUND, 16'd0));
    plan.push_back(text_row(8'hFF, 1'b1, CHK_NONE, STATUS_FOUND, 16'd0));
    // two-byte pattern, unused pattern bytes hold junk
    plan.push_back(cfg_row(64'hA5A5_A5A5_A5A5_4241, '1, 5'd2, 1'b0));
    plan.push_back(text_row(8'h41, 1'b0, CHK_NONE, STATUS_FOUND, 16'd0));
    plan.push_back(text_row(8'h42, 1'b0, CHK_RESULT, STATUS_FOUND, 16'd0));
    plan.push_back(text_row(8'h43, 1'b1, CHK_NONE, STATUS_FOUND, 16'd0));
    plan.push_back(text_row(8'h43, 1'b1, CHK_RESULT, STATUS_NOT_FOUND, 16'd0));
    // double-byte: a trail byte never starts a match
    plan.push_back(cfg_row(64'h4182, 64'h0, 5'd2, 1'b1));
    plan.push_back(text_row(8'h82, 1'b0, CHK_MODEL, STATUS_FOUND, 16'd0));
    plan.push_back(text_row(8'h82, 1'b0, CHK_MODEL, STATUS_FOUND, 16'd0));
    plan.push_back(text_row(8'h41, 1'b1, CHK_MODEL, STATUS_FOUND, 16'd0));
    plan.push_back(text_row(8'h41, 1'b0, CHK_MODEL, STATUS_FOUND, 16'd0));
    plan.push_back(text_row(8'h82, 1'b0, CHK_MODEL, STATUS_FOUND, 16'd0));
    plan.push_back(text_row(8'h41, 1'b1, CHK_MODEL, STATUS_FOUND, 16'd0));
    // length field above the window size clamps to the full window
    plan.push_back(cfg_row('1, '1, 5'd31, 1'b0));
    for (int i = 0; i < 15; i++) begin
      plan.push_back(text_row(8'hFF, 1'b0, CHK_MODEL, STATUS_FOUND, 16'd0));
    end
    plan.push_back(text_row(8'hFF, 1'b1, CHK_RESULT, STATUS_FOUND, 16'd0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        load_search(plan[k].lo, plan[k].hi, plan[k].len, plan[k].mode);
      end else begin
        send_byte(plan[k].b, plan[k].is_last);
        if (search_step(plan[k].b, plan[k].is_last, r) && plan[k].chk == CHK_MODEL) begin
          pending_results.push_back(r);
        end
        if (plan[k].chk == CHK_RESULT) begin
          r.status = plan[k].st;
          r.position = plan[k].pos;
          pending_results.push_back(r);
        end
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      phase_items = 0;
      while (phase_items < RANDOM_ITEMS / 4) begin
        if (phase_items == 0 || $urandom_range(2) == 0) begin
          for (int j = 0; j < 16; j++) pat[j*8 +: 8] = pick_byte();
          case ($urandom_range(9))
            0: n = 0;
            1: n = 16;
            2: n = $urandom_range(31, 17);
            default: n = $urandom_range(16, 1);
          endcase
          load_search(pat[63:0], pat[127:64], 5'(n), 1'($urandom_range(1)));
        end
        eff = (cfg_len > 5'd16) ? 16 : int'(cfg_len);
        n = $urandom_range(eff + 10, 1);
        kind = $urandom_range(9);
        txt.delete();
        for (int i = 0; i < n; i++) begin
          txt.push_back(kind == 0 ? 8'($urandom_range(255)) : pick_byte());
        end
        // plant the pattern in most texts, sometimes with one bit broken
        if (kind >= 3 && eff > 0 && eff <= n) begin
          ofs = $urandom_range(n - eff);
          for (int j = 0; j < eff; j++) txt[ofs+j] = cfg_pattern[j*8 +: 8];
          if (kind == 3) begin
            idx = ofs + $urandom_range(eff - 1);
            txt[idx] = txt[idx] ^ (8'h01 << $urandom_range(7));
          end
        end
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(39) == 0) settle(0);
          send_and_predict(txt[i], i == n - 1);
          phase_items++;
        end
      end
    end

    settle(8);
    while (pending_results.size() != 0) begin
      r = pending_results.pop_front();
      flag_mismatch($sformatf("no result for status %0d position %0d", r.status, r.position));
    end
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/ssd_pkg.sv
design/ssd_cell.sv
design/ssd_skid.sv
design/substring_search_dbcs_aware.sv
tb/testbench.sv
